// ===== rtl/core/cne_pkg.sv =====
// ----------------------------------------------------------------------------
// cne_pkg
// Shared types and constants for the charstring number encrypter.
// ----------------------------------------------------------------------------
package cne_pkg;

    // register map, index = paddr / 4
    typedef enum logic [1:0] {
        REG_KEY_SEED = 2'd0,
        REG_KEY_MUL  = 2'd1,
        REG_KEY_ADD  = 2'd2
    } reg_idx_t;

    localparam int unsigned PADDR_W = 4;

    localparam logic [15:0] KEY_SEED_RST = 16'd4330;
    localparam logic [15:0] KEY_MUL_RST  = 16'd52845;
    localparam logic [15:0] KEY_ADD_RST  = 16'd22719;

    // item kinds
    typedef enum logic [1:0] {
        KIND_NUMBER  = 2'd0,
        KIND_OPER    = 2'd1,
        KIND_ESC_OP  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // number coding
    localparam int NUM_ONE_MAX   = 107;
    localparam int NUM_TWO_MIN   = 108;
    localparam int NUM_TWO_MAX   = 1131;
    localparam logic [7:0] ONE_BYTE_BIAS = 8'd139;
    localparam logic [7:0] POS_LEAD_BASE = 8'd247;
    localparam logic [7:0] NEG_LEAD_BASE = 8'd251;
    localparam logic [7:0] LONG_LEAD     = 8'd255;
    localparam logic [7:0] ESCAPE_BYTE   = 8'd12;

    localparam int unsigned MAX_BYTES = 5;
    localparam int unsigned NBYTE_W   = 3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic load;   // take the input item, code it, apply restart
        logic emit;   // encrypt head byte into the output register
    } cmd_t;

    typedef struct packed {
        logic zero_len;  // input item codes to no bytes
        logic last;      // head byte is the final one of the item
        logic rem_zero;  // no bytes pending
    } stat_t;

endpackage

// ===== rtl/core/cne_ctrl.sv =====
// ----------------------------------------------------------------------------
// cne_ctrl
// Sequencer: accepts one item, then steps its bytes into the output register.
// ----------------------------------------------------------------------------
module cne_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  cne_pkg::stat_t  stat,
    output cne_pkg::cmd_t   cmd
);

    cne_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == cne_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.load   = s_valid && (state_reg == cne_pkg::ST_IDLE);
        cmd.emit   = (state_reg == cne_pkg::ST_EMIT) && out_free;
        state_next = state_reg;
        unique case (state_reg)
            cne_pkg::ST_IDLE: begin
                if (cmd.load && !stat.zero_len) begin
                    state_next = cne_pkg::ST_EMIT;
                end
            end
            cne_pkg::ST_EMIT: begin
                if (cmd.emit && stat.last) begin
                    state_next = cne_pkg::ST_IDLE;
                end
            end
            default: state_next = cne_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cne_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cne_pkg::ST_EMIT |-> !stat.rem_zero)
        else $error("emit state with no pending bytes");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && stat.last |=> state_reg == cne_pkg::ST_IDLE && m_valid_reg)
        else $error("final byte did not end the item");

    a_load_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load && !stat.zero_len |=> state_reg == cne_pkg::ST_EMIT && !stat.rem_zero)
        else $error("loaded item did not start emitting");
`endif

endmodule

// ===== rtl/core/cne_dp.sv =====
// ----------------------------------------------------------------------------
// cne_dp
// Datapath: number/operator coding, byte buffer, key update, byte counter.
// ----------------------------------------------------------------------------
module cne_dp #(
    parameter int MAX_LEN = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cne_pkg::cmd_t       cmd,
    output cne_pkg::stat_t      stat,
    input  logic [15:0]         key_seed,
    input  logic [15:0]         key_mul,
    input  logic [15:0]         key_add,
    input  logic [1:0]          s_kind,
    input  logic signed [31:0]  s_value,
    input  logic                s_restart,
    output logic [7:0]          m_cipher_byte,
    output logic [11:0]         m_byte_index,
    output logic                m_overflow,
    output logic                m_last
);

    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam logic [CntW-1:0] MaxLenC = CntW'(MAX_LEN);

    // ---------------- coding of the input item ----------------
    logic [7:0]             enc_bytes [cne_pkg::MAX_BYTES];
    logic [cne_pkg::NBYTE_W-1:0] enc_n;
    logic signed [31:0]     v_plus_bias;
    logic signed [31:0]     v_pos_w;
    logic signed [31:0]     v_neg_w;
    logic [9:0]             w_pos;
    logic [9:0]             w_neg;
    logic                   in_one, in_pos, in_neg;

    always_comb begin
        v_plus_bias = s_value + 32'sd139;
        v_pos_w     = s_value - 32'(cne_pkg::NUM_TWO_MIN);
        v_neg_w     = -(s_value + 32'(cne_pkg::NUM_TWO_MIN));
        w_pos       = v_pos_w[9:0];
        w_neg       = v_neg_w[9:0];
        in_one = (s_value >= -cne_pkg::NUM_ONE_MAX) && (s_value <= cne_pkg::NUM_ONE_MAX);
        in_pos = (s_value >= cne_pkg::NUM_TWO_MIN) && (s_value <= cne_pkg::NUM_TWO_MAX);
        in_neg = (s_value >= -cne_pkg::NUM_TWO_MAX) && (s_value <= -cne_pkg::NUM_TWO_MIN);

        for (int i = 0; i < cne_pkg::MAX_BYTES; i++) begin
            enc_bytes[i] = 8'd0;
        end
        enc_n = '0;

        unique case (cne_pkg::kind_t'(s_kind))
            cne_pkg::KIND_NUMBER: begin
                if (in_one) begin
                    enc_bytes[0] = v_plus_bias[7:0];
                    enc_n        = 3'd1;
                end else if (in_pos) begin
                    enc_bytes[0] = cne_pkg::POS_LEAD_BASE + {6'd0, w_pos[9:8]};
                    enc_bytes[1] = w_pos[7:0];
                    enc_n        = 3'd2;
                end else if (in_neg) begin
                    enc_bytes[0] = cne_pkg::NEG_LEAD_BASE + {6'd0, w_neg[9:8]};
                    enc_bytes[1] = w_neg[7:0];
                    enc_n        = 3'd2;
                end else begin
                    enc_bytes[0] = cne_pkg::LONG_LEAD;
                    enc_bytes[1] = s_value[31:24];
                    enc_bytes[2] = s_value[23:16];
                    enc_bytes[3] = s_value[15:8];
                    enc_bytes[4] = s_value[7:0];
                    enc_n        = 3'd5;
                end
            end
            cne_pkg::KIND_OPER: begin
                enc_bytes[0] = s_value[7:0];
                enc_n        = 3'd1;
            end
            cne_pkg::KIND_ESC_OP: begin
                enc_bytes[0] = cne_pkg::ESCAPE_BYTE;
                enc_bytes[1] = s_value[7:0];
                enc_n        = 3'd2;
            end
            cne_pkg::KIND_NONE: begin
                enc_n = '0;
            end
            default: enc_n = '0;
        endcase
    end

    // ---------------- byte buffer (shifts toward slot 0) ----------------
    logic [7:0]                  buf_reg [cne_pkg::MAX_BYTES];
    logic [cne_pkg::NBYTE_W-1:0] rem_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            buf_reg <= enc_bytes;
        end else if (cmd.emit) begin
            for (int i = 0; i < cne_pkg::MAX_BYTES - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[cne_pkg::MAX_BYTES-1] <= 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (cmd.load) begin
            rem_reg <= enc_n;
        end else if (cmd.emit) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    assign stat.zero_len = (enc_n == '0);
    assign stat.last     = (rem_reg == 3'd1);
    assign stat.rem_zero = (rem_reg == '0);

    // ---------------- encryption and counter ----------------
    logic [15:0]     key_reg, key_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW:0]   count_p1;
    logic [7:0]      cipher;
    logic [15:0]     key_sum;
    logic [31:0]     count_ext;

    always_comb begin
        cipher    = buf_reg[0] ^ key_reg[15:8];
        key_sum   = key_reg + {8'd0, cipher};
        count_p1  = {1'b0, count_reg} + {{CntW{1'b0}}, 1'b1};
        count_ext = 32'(count_reg);
        key_next   = key_reg;
        count_next = count_reg;
        if (cmd.load) begin
            if (s_restart) begin
                key_next   = key_seed;
                count_next = '0;
            end
        end else if (cmd.emit) begin
            key_next = 16'(key_sum * key_mul) + key_add;
            if (count_reg < MaxLenC) begin
                count_next = count_p1[CntW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= cne_pkg::KEY_SEED_RST;
            count_reg <= '0;
        end else begin
            key_reg   <= key_next;
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_cipher_byte <= cipher;
            m_byte_index  <= count_ext[11:0];
            m_overflow    <= (count_p1 >= {1'b0, MaxLenC});
            m_last        <= stat.last;
        end
    end

endmodule

// ===== rtl/core/charstring_number_encrypter.sv =====
// ----------------------------------------------------------------------------
// charstring_number_encrypter
// Codes charstring numbers and operators into bytes and encrypts each byte
// with the running charstring key.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_kind s_value s_restart
//  m_      | out       | m_valid m_ready m_cipher_byte m_byte_index m_overflow m_last
//  apb     | in/out    | psel penable pwrite paddr pwdata prdata pready
//
//  An item is accepted, then coded to 1..5 bytes that go out one per cycle
//  while the output register is free; the key update feeds each byte's cipher into the next.
//  An item that codes to no bytes is accepted and the block stays idle.
//  Reset is synchronous, active low; key and byte count return to their
//  reset values, configuration registers to their defaults.
//  A stalled m_ready holds the byte sequence; s_ready is high between items.
// ----------------------------------------------------------------------------
module charstring_number_encrypter #(
    parameter int MAX_LEN = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic signed [31:0]           s_value,
    input  logic                         s_restart,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_cipher_byte,
    output logic [11:0]                  m_byte_index,
    output logic                         m_overflow,
    output logic                         m_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cne_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [15:0]       seed_reg, mul_reg, add_reg;
    logic              wr_en;
    cne_pkg::reg_idx_t reg_sel;
    cne_pkg::cmd_t     cmd;
    cne_pkg::stat_t    stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = cne_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= cne_pkg::KEY_SEED_RST;
            mul_reg  <= cne_pkg::KEY_MUL_RST;
            add_reg  <= cne_pkg::KEY_ADD_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                cne_pkg::REG_KEY_SEED: seed_reg <= pwdata[15:0];
                cne_pkg::REG_KEY_MUL:  mul_reg  <= pwdata[15:0];
                cne_pkg::REG_KEY_ADD:  add_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            cne_pkg::REG_KEY_SEED: prdata = {16'd0, seed_reg};
            cne_pkg::REG_KEY_MUL:  prdata = {16'd0, mul_reg};
            cne_pkg::REG_KEY_ADD:  prdata = {16'd0, add_reg};
            default:               prdata = 32'd0;
        endcase
    end

    cne_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cne_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .key_seed      (seed_reg),
        .key_mul       (mul_reg),
        .key_add       (add_reg),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .s_restart     (s_restart),
        .m_cipher_byte (m_cipher_byte),
        .m_byte_index  (m_byte_index),
        .m_overflow    (m_overflow),
        .m_last        (m_last)
    );

endmodule
